@@ hw/rtl/esvf_pkg.sv @@
package esvf_pkg;

   localparam int unsigned FIELD_COORD_BITS = 10;
   localparam int unsigned VALUE_BITS       = 16;
   localparam int unsigned CENTER_BITS      = 16;
   localparam int unsigned WEIGHT_BITS      = 32;
   localparam int unsigned TERM_BITS        = 64;
   localparam int unsigned QSUM_BITS        = 66;
   localparam int unsigned CSR_INDEX_BITS   = 3;
   localparam int unsigned CSR_DATA_BITS    = 64;
   localparam int unsigned AXES             = 3;

   // 1 + 1e-6 scaled by 2^39, rounded up
   localparam logic [QSUM_BITS-1:0] SHELL_LIMIT = 66'd549756363644;

   localparam logic [CSR_INDEX_BITS-1:0] REG_OUTER_CENTER  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HOLLOW_CENTER = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WEIGHT_X      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WEIGHT_Y      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WEIGHT_Z      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FILL_VALUE    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_APPEND_MODE   = 3'd6;

   typedef struct packed {
      logic [FIELD_COORD_BITS-1:0] voxel_x;
      logic [FIELD_COORD_BITS-1:0] voxel_y;
      logic [FIELD_COORD_BITS-1:0] voxel_z;
      logic [VALUE_BITS-1:0]       old_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] new_value;
      logic                  in_shell;
   } rsp_type;

   typedef struct packed {
      logic [AXES-1:0][CENTER_BITS-1:0] outer_center;
      logic [AXES-1:0][CENTER_BITS-1:0] hollow_center;
      logic [AXES-1:0][WEIGHT_BITS-1:0] outer_weight;
      logic [AXES-1:0][WEIGHT_BITS-1:0] hollow_weight;
      logic [VALUE_BITS-1:0]            fill_value;
      logic                             append_mode;
   } cfg_type;

endpackage

@@ hw/rtl/esvf_csr.sv @@
module esvf_csr
   import esvf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_OUTER_CENTER: begin
               cfg_in.outer_center = csr_wdata[AXES*CENTER_BITS-1:0];
            end
            REG_HOLLOW_CENTER: begin
               cfg_in.hollow_center = csr_wdata[AXES*CENTER_BITS-1:0];
            end
            REG_WEIGHT_X: begin
               cfg_in.outer_weight[0]  = csr_wdata[WEIGHT_BITS-1:0];
               cfg_in.hollow_weight[0] = csr_wdata[2*WEIGHT_BITS-1:WEIGHT_BITS];
            end
            REG_WEIGHT_Y: begin
               cfg_in.outer_weight[1]  = csr_wdata[WEIGHT_BITS-1:0];
               cfg_in.hollow_weight[1] = csr_wdata[2*WEIGHT_BITS-1:WEIGHT_BITS];
            end
            REG_WEIGHT_Z: begin
               cfg_in.outer_weight[2]  = csr_wdata[WEIGHT_BITS-1:0];
               cfg_in.hollow_weight[2] = csr_wdata[2*WEIGHT_BITS-1:WEIGHT_BITS];
            end
            REG_FILL_VALUE: begin
               cfg_in.fill_value = csr_wdata[VALUE_BITS-1:0];
            end
            REG_APPEND_MODE: begin
               cfg_in.append_mode = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/esvf_axis.sv @@
module esvf_axis
   import esvf_pkg::*;
#(
   parameter int unsigned COORD_BITS = 10
)
(
   input  logic                        clock,
   input  logic                        advance,
   input  logic [FIELD_COORD_BITS-1:0] coord,
   input  logic [CENTER_BITS-1:0]      center,
   input  logic [WEIGHT_BITS-1:0]      weight,
   output logic [TERM_BITS-1:0]        term
);

   localparam logic [CENTER_BITS-1:0] COORD_MASK =
      CENTER_BITS'((17'd1 << COORD_BITS) - 17'd1);

   logic [CENTER_BITS-1:0]   coord_ext;
   logic [CENTER_BITS-1:0]   scaled;
   logic [CENTER_BITS-1:0]   mag_in;
   logic [CENTER_BITS-1:0]   mag_ff;
   logic [2*CENTER_BITS-1:0] sq_ff;
   logic [WEIGHT_BITS-1:0]   weight_ff;
   logic [TERM_BITS-1:0]     term_ff;

   // coordinate in 12.4, distance to center
   always_comb begin
      coord_ext = CENTER_BITS'(coord) & COORD_MASK;
      scaled    = CENTER_BITS'(coord_ext << 4);
      if (scaled >= center) begin
         mag_in = scaled - center;
      end else begin
         mag_in = center - scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff    <= mag_in;
         sq_ff     <= mag_ff * mag_ff;
         weight_ff <= weight;
         term_ff   <= TERM_BITS'(sq_ff) * TERM_BITS'(weight_ff);
      end
   end

   assign term = term_ff;

endmodule

@@ hw/rtl/esvf_shell.sv @@
module esvf_shell
   import esvf_pkg::*;
(
   input  logic                           clock,
   input  logic                           advance,
   input  logic [AXES-1:0][TERM_BITS-1:0] outer_term,
   input  logic [AXES-1:0][TERM_BITS-1:0] hollow_term,
   input  logic [VALUE_BITS-1:0]          old_value,
   input  logic [VALUE_BITS-1:0]          fill_value,
   input  logic                           append_mode,
   output rsp_type                        rsp
);

   logic [QSUM_BITS-1:0]  qo_ff;
   logic [QSUM_BITS-1:0]  qh_ff;
   logic [VALUE_BITS-1:0] old_ff;
   logic                  shell;
   rsp_type               rsp_in;
   rsp_type               rsp_ff;

   // exact sum is wide enough that it never wraps
   always_comb begin
      shell = (qo_ff < SHELL_LIMIT) && (qh_ff >= SHELL_LIMIT);
      rsp_in.in_shell = shell;
      if (shell) begin
         rsp_in.new_value = fill_value;
      end else if (append_mode) begin
         rsp_in.new_value = old_ff;
      end else begin
         rsp_in.new_value = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         qo_ff  <= QSUM_BITS'(outer_term[0]) + QSUM_BITS'(outer_term[1])
                 + QSUM_BITS'(outer_term[2]);
         qh_ff  <= QSUM_BITS'(hollow_term[0]) + QSUM_BITS'(hollow_term[1])
                 + QSUM_BITS'(hollow_term[2]);
         old_ff <= old_value;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

@@ hw/rtl/ellipsoid_shell_voxel_fill.sv @@
// an accepted transaction passes through every stage below before rsp_valid
// throughput: one transaction per cycle unless stalled; stages are distance, square,
// weight multiply, quadratic-form sum, compare and output register
// the whole pipeline holds while the output register is stalled
// reset: synchronous, clears valid bits and all configuration registers
module ellipsoid_shell_voxel_fill
   import esvf_pkg::*;
#(
   parameter int unsigned COORD_BITS = 10
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int unsigned DEPTH = 5;

   cfg_type                        cfg;
   logic                           advance;
   logic [DEPTH-1:0]               valid_ff;
   logic [DEPTH-1:0]               valid_in;
   logic [2:0][VALUE_BITS-1:0]     old_ff;
   logic [AXES-1:0][FIELD_COORD_BITS-1:0] coord;
   logic [AXES-1:0][TERM_BITS-1:0] outer_term;
   logic [AXES-1:0][TERM_BITS-1:0] hollow_term;

   assign advance   = !valid_ff[DEPTH-1] || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[DEPTH-1];

   assign coord[0] = req_data.voxel_x;
   assign coord[1] = req_data.voxel_y;
   assign coord[2] = req_data.voxel_z;

   esvf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      esvf_axis #(.COORD_BITS(COORD_BITS)) u_outer (
         .clock   (clock),
         .advance (advance),
         .coord   (coord[a]),
         .center  (cfg.outer_center[a]),
         .weight  (cfg.outer_weight[a]),
         .term    (outer_term[a])
      );
      esvf_axis #(.COORD_BITS(COORD_BITS)) u_hollow (
         .clock   (clock),
         .advance (advance),
         .coord   (coord[a]),
         .center  (cfg.hollow_center[a]),
         .weight  (cfg.hollow_weight[a]),
         .term    (hollow_term[a])
      );
   end

   esvf_shell u_shell (
      .clock       (clock),
      .advance     (advance),
      .outer_term  (outer_term),
      .hollow_term (hollow_term),
      .old_value   (old_ff[2]),
      .fill_value  (cfg.fill_value),
      .append_mode (cfg.append_mode),
      .rsp         (rsp_data)
   );

   assign valid_in = {valid_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // old value rides alongside the axis stages
   always_ff @(posedge clock) begin
      if (advance) begin
         old_ff <= {old_ff[1:0], req_data.old_value};
      end
   end

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff[DEPTH-2:0]))
      else $error("pipeline valid bits moved while stalled");

   a_fill_in_shell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_shell |-> rsp_data.new_value == cfg.fill_value)
      else $error("shell voxel without fill value");

   a_zero_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.in_shell && !cfg.append_mode |-> rsp_data.new_value == '0)
      else $error("voxel outside shell not cleared");

   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(valid_ff[DEPTH-2]))
      else $error("response without a transaction in flight");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench
   import esvf_pkg::*;
();

   localparam int unsigned SHELL_REGS     = 7;
   localparam int unsigned DIRECTED_ROWS  = 22;
   localparam int unsigned RANDOM_PHASES  = 8;
   localparam int unsigned PHASE_ITEMS    = 75;
   localparam int unsigned DRAIN_CYCLES   = 12;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned QUIET_LIMIT    = 5000;
   localparam int unsigned HOLD_PHASE     = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NONE = 3'd7;

   typedef logic [SHELL_REGS-1:0][CSR_DATA_BITS-1:0] shell_setting_type;

   typedef struct {
      int unsigned setting;
      req_type     voxel;
      bit          typed;
      rsp_type     want;
   } voxel_row_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   logic [CSR_DATA_BITS-1:0] shell_reg [SHELL_REGS] = '{default: '0};
   rsp_type                  expected_voxel_q [$];
   shell_setting_type        directed_setting [4];

   int unsigned mismatch_count     = 0;
   int unsigned quiet_cycles       = 0;
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_left          = 0;
   bit          hold_req           = 1'b0;
   bit          hold_done          = 1'b0;
   int unsigned tgt_voxel [AXES];
   int unsigned tgt_reach          = 1;

   voxel_row_type directed_rows [DIRECTED_ROWS] = '{
      '{0, '{10'd0,    10'd0,    10'd0,    16'h0000}, 1'b1, '{16'h0000, 1'b0}},
      '{0, '{10'd1023, 10'd1023, 10'd1023, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0}},
      '{0, '{10'd1023, 10'd0,    10'd512,  16'hAAAA}, 1'b1, '{16'h0000, 1'b0}},
      '{0, '{10'd0,    10'd1023, 10'd341,  16'h5555}, 1'b1, '{16'h0000, 1'b0}},
      '{0, '{10'd512,  10'd512,  10'd512,  16'h8001}, 1'b1, '{16'h0000, 1'b0}},
      '{1, '{10'd512,  10'd512,  10'd512,  16'h1234}, 1'b0, '{16'h0000, 1'b0}},
      '{1, '{10'd587,  10'd512,  10'd512,  16'h0000}, 1'b0, '{16'h0000, 1'b0}},
      '{1, '{10'd612,  10'd512,  10'd512,  16'h4321}, 1'b0, '{16'h0000, 1'b0}},
      '{1, '{10'd613,  10'd512,  10'd512,  16'hFFFF}, 1'b0, '{16'h0000, 1'b0}},
      '{1, '{10'd462,  10'd512,  10'd512,  16'h0F0F}, 1'b0, '{16'h0000, 1'b0}},
      '{1, '{10'd461,  10'd512,  10'd512,  16'h0F0F}, 1'b0, '{16'h0000, 1'b0}},
      '{1, '{10'd560,  10'd560,  10'd560,  16'h7777}, 1'b0, '{16'h0000, 1'b0}},
      '{1, '{10'd0,    10'd0,    10'd0,    16'hFFFF}, 1'b0, '{16'h0000, 1'b0}},
      '{2, '{10'd0,    10'd0,    10'd0,    16'hFFFF}, 1'b1, '{16'h0000, 1'b0}},
      '{2, '{10'd1023, 10'd1023, 10'd1023, 16'h1234}, 1'b1, '{16'h0000, 1'b0}},
      '{2, '{10'd1023, 10'd0,    10'd1023, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0}},
      '{3, '{10'd100,  10'd0,    10'd0,    16'hFFFF}, 1'b0, '{16'h0000, 1'b0}},
      '{3, '{10'd102,  10'd1023, 10'd1023, 16'hFFFF}, 1'b0, '{16'h0000, 1'b0}},
      '{3, '{10'd104,  10'd512,  10'd0,    16'h0000}, 1'b0, '{16'h0000, 1'b0}},
      '{3, '{10'd105,  10'd0,    10'd1023, 16'h0000}, 1'b0, '{16'h0000, 1'b0}},
      '{3, '{10'd99,   10'd77,   10'd33,   16'h1111}, 1'b0, '{16'h0000, 1'b0}},
      '{3, '{10'd96,   10'd1,    10'd2,    16'h2222}, 1'b0, '{16'h0000, 1'b0}}
   };

   ellipsoid_shell_voxel_fill dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   // saturating sum of the three weighted squared distances
   function automatic logic [63:0] shell_quad_sum(req_type v, bit hollow);
      logic [47:0]                 center;
      logic [64:0]                 acc;
      logic [16:0]                 pos;
      logic [16:0]                 cen;
      logic [16:0]                 mag;
      logic [63:0]                 mag64;
      logic [63:0]                 w64;
      logic [FIELD_COORD_BITS-1:0] coord;
      center = hollow ? shell_reg[REG_HOLLOW_CENTER][47:0] : shell_reg[REG_OUTER_CENTER][47:0];
      acc = '0;
      for (int a = 0; a < AXES; a++) begin
         case (a)
            0: coord = v.voxel_x;
            1: coord = v.voxel_y;
            default: coord = v.voxel_z;
         endcase
         pos   = {3'b000, coord, 4'b0000};
         cen   = {1'b0, center[16*a +: 16]};
         mag   = (pos >= cen) ? pos - cen : cen - pos;
         mag64 = 64'(mag);
         w64   = hollow ? 64'(shell_reg[REG_WEIGHT_X + a][63:32])
                        : 64'(shell_reg[REG_WEIGHT_X + a][31:0]);
         acc   = acc + {1'b0, mag64 * mag64 * w64};
         if (acc[64]) begin
            acc = {1'b0, {64{1'b1}}};
         end
      end
      return acc[63:0];
   endfunction

   function automatic rsp_type predict_fill(req_type v);
      rsp_type r;
      bit      shell;
      shell = (shell_quad_sum(v, 1'b0) < SHELL_LIMIT) && (shell_quad_sum(v, 1'b1) >= SHELL_LIMIT);
      r.in_shell = shell;
      if (shell) begin
         r.new_value = shell_reg[REG_FILL_VALUE][VALUE_BITS-1:0];
      end else if (shell_reg[REG_APPEND_MODE][0]) begin
         r.new_value = v.old_value;
      end else begin
         r.new_value = '0;
      end
      return r;
   endfunction

   function automatic shell_setting_type make_shell_setting(int unsigned reach_max);
      shell_setting_type s;
      int unsigned       ro;
      int unsigned       rh;
      int unsigned       r;
      int                hc_i;
      logic [15:0]       oc;
      logic [31:0]       wo;
      logic [31:0]       wh;
      s  = '0;
      ro = $urandom_range(1, reach_max);
      rh = $urandom_range(1, ro);
      tgt_reach = ro;
      for (int a = 0; a < AXES; a++) begin
         if ($urandom_range(0, 7) == 0) begin
            oc = 16'($urandom);
         end else begin
            oc = 16'($urandom_range(0, 1023) * 16 + $urandom_range(0, 15));
         end
         tgt_voxel[a] = ((oc >> 4) > 1023) ? 1023 : (oc >> 4);
         hc_i = int'(oc) + int'($urandom_range(0, 8 * ro)) - int'(4 * ro);
         if (hc_i < 0) hc_i = 0;
         if (hc_i > 65535) hc_i = 65535;
         r  = $urandom_range((ro + 1) / 2, ro);
         wo = 32'(64'h8000_0000 / 64'(r * r));
         r  = $urandom_range((rh + 1) / 2, rh);
         wh = 32'(64'h8000_0000 / 64'(r * r));
         if ($urandom_range(0, 9) == 0) wo = '0;
         if ($urandom_range(0, 9) == 0) wh = '0;
         if ($urandom_range(0, 11) == 0) wo = $urandom;
         if ($urandom_range(0, 11) == 0) wh = $urandom;
         s[REG_OUTER_CENTER][16*a +: 16]  = oc;
         s[REG_HOLLOW_CENTER][16*a +: 16] = 16'(hc_i);
         s[REG_WEIGHT_X + a]              = {wh, wo};
      end
      s[REG_OUTER_CENTER][63:48]  = 16'($urandom);
      s[REG_HOLLOW_CENTER][63:48] = 16'($urandom);
      s[REG_FILL_VALUE]           = {$urandom, $urandom};
      s[REG_APPEND_MODE]          = {$urandom, $urandom};
      return s;
   endfunction

   function automatic req_type random_voxel();
      req_type     v;
      int unsigned c;
      bit          stray;
      stray = ($urandom_range(0, 99) < 15);
      for (int a = 0; a < AXES; a++) begin
         if (stray) begin
            c = $urandom_range(0, 1023);
         end else begin
            c = tgt_voxel[a] + $urandom_range(0, 2 * tgt_reach + 4);
            c = (c < tgt_reach + 2) ? 0 : c - tgt_reach - 2;
            if (c > 1023) c = 1023;
         end
         case (a)
            0: v.voxel_x = FIELD_COORD_BITS'(c);
            1: v.voxel_y = FIELD_COORD_BITS'(c);
            default: v.voxel_z = FIELD_COORD_BITS'(c);
         endcase
      end
      case ($urandom_range(0, 9))
         0: v.old_value = '0;
         1: v.old_value = '1;
         default: v.old_value = VALUE_BITS'($urandom);
      endcase
      return v;
   endfunction

   task automatic write_shell_setting(input shell_setting_type s);
      for (int i = 0; i < SHELL_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_INDEX_BITS'(i);
         csr_wdata <= s[i];
         @(posedge clock);
         case (CSR_INDEX_BITS'(i))
            REG_OUTER_CENTER, REG_HOLLOW_CENTER: shell_reg[i] = {16'h0, s[i][47:0]};
            REG_FILL_VALUE: shell_reg[i] = {48'h0, s[i][15:0]};
            REG_APPEND_MODE: shell_reg[i] = {63'h0, s[i][0]};
            default: shell_reg[i] = s[i];
         endcase
      end
      csr_index <= REG_NONE;
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_voxel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_voxel(input req_type v, input bit typed, input rsp_type want);
      req_valid <= 1'b1;
      req_data  <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_voxel_q.push_back(typed ? want : predict_fill(v));
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (receiver_stall_pct != 0) && ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_voxel_q.size() == 0) begin
               $error("unexpected transaction: new_value %h in_shell %b",
                      rsp_data.new_value, rsp_data.in_shell);
               mismatch_count++;
            end else begin
               want = expected_voxel_q.pop_front();
               if (rsp_data.new_value !== want.new_value) begin
                  $error("new_value: expected %h, actual %h", want.new_value, rsp_data.new_value);
                  mismatch_count++;
               end
               if (rsp_data.in_shell !== want.in_shell) begin
                  $error("in_shell: expected %b, actual %b", want.in_shell, rsp_data.in_shell);
                  mismatch_count++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int unsigned cur_setting;
      int unsigned mode;
      directed_setting[0] = '0;
      // sphere at 512,512,512: outer radius 100, hollow radius 50, append
      directed_setting[1][REG_OUTER_CENTER]  = 64'hDEAD_2000_2000_2000;
      directed_setting[1][REG_HOLLOW_CENTER] = 64'h0000_2000_2000_2000;
      directed_setting[1][REG_WEIGHT_X]      = {32'd858993, 32'd214748};
      directed_setting[1][REG_WEIGHT_Y]      = {32'd858993, 32'd214748};
      directed_setting[1][REG_WEIGHT_Z]      = {32'd858993, 32'd214748};
      directed_setting[1][REG_FILL_VALUE]    = 64'h1234_5678_9ABC_ABCD;
      directed_setting[1][REG_APPEND_MODE]   = 64'hFFFF_FFFF_FFFF_FFFF;
      // all-ones centers and weights, sums saturate
      directed_setting[2][REG_OUTER_CENTER]  = '1;
      directed_setting[2][REG_HOLLOW_CENTER] = '1;
      directed_setting[2][REG_WEIGHT_X]      = '1;
      directed_setting[2][REG_WEIGHT_Y]      = '1;
      directed_setting[2][REG_WEIGHT_Z]      = '1;
      directed_setting[2][REG_FILL_VALUE]    = 64'h0000_0000_0000_FFFF;
      directed_setting[2][REG_APPEND_MODE]   = 64'h0000_0000_0000_0002;
      // x axis only, outer radius 4, hollow radius 1, y and z unbounded
      directed_setting[3][REG_OUTER_CENTER]  = 64'h0000_0000_0000_0640;
      directed_setting[3][REG_HOLLOW_CENTER] = 64'hFFFF_0000_0000_0640;
      directed_setting[3][REG_WEIGHT_X]      = {32'h8000_0000, 32'h0800_0000};
      directed_setting[3][REG_WEIGHT_Y]      = '0;
      directed_setting[3][REG_WEIGHT_Z]      = '0;
      directed_setting[3][REG_FILL_VALUE]    = 64'hFFFF_FFFF_FFFF_0001;
      directed_setting[3][REG_APPEND_MODE]   = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      cur_setting = 0;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].setting != cur_setting) begin
            req_valid <= 1'b0;
            wait_drained();
            cur_setting = directed_rows[i].setting;
            write_shell_setting(directed_setting[cur_setting]);
         end
         send_voxel(directed_rows[i].voxel, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         req_valid <= 1'b0;
         wait_drained();
         write_shell_setting(make_shell_setting((phase % 2 == 1) ? 16 : 200));
         mode = phase % 4;
         sender_idle_pct    = (mode == 1) ? 50 : (mode == 3) ? 36 : 0;
         receiver_stall_pct = (mode == 2) ? 50 : (mode == 3) ? 36 : 0;
         if (phase == HOLD_PHASE) begin
            hold_req <= 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_voxel(random_voxel(), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
